// ----- rtl/pow_hash_threshold_check_defines.svh -----
// Assertion macros shared by the proof-of-work checker RTL
`ifndef POW_HASH_THRESHOLD_CHECK_DEFINES_SVH
`define POW_HASH_THRESHOLD_CHECK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BHC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BHC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/bhc_pkg.sv -----
// Types, constants and mixing function of the BLAKE2b proof-of-work checker
package bhc_pkg;

    localparam int ROUNDS     = 12;
    localparam int PHASES     = 4;
    localparam int CELL_COUNT = ROUNDS * PHASES;

    typedef logic [15:0][63:0] vstate_t;
    typedef logic [3:0][63:0]  hash_words_t;

    typedef struct packed {
        logic    valid;
        logic [63:0] nonce;
        vstate_t v;
    } stage_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } quad_t;

    typedef enum logic [2:0] {
        REG_HASH_W0    = 3'd0,
        REG_HASH_W1    = 3'd1,
        REG_HASH_W2    = 3'd2,
        REG_HASH_W3    = 3'd3,
        REG_DIFFICULTY = 3'd4
    } reg_index_t;

    localparam logic [7:0][63:0] BLK_IV = '{
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    // parameter block: 8-byte digest, no key, fanout 1, depth 1
    localparam logic [63:0] H0 = BLK_IV[0] ^ 64'h0000_0000_0101_0008;

    localparam logic [63:0] MSG_BYTES = 64'd40;

    localparam logic [3:0] MSG_PERM [ROUNDS][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    function automatic vstate_t init_state();
        vstate_t v;
        for (int i = 0; i < 8; i++) begin
            v[i]     = BLK_IV[i];
            v[8 + i] = BLK_IV[i];
        end
        v[0]  = H0;
        v[12] = BLK_IV[4] ^ MSG_BYTES;
        v[14] = ~BLK_IV[6];
        return v;
    endfunction

    // half of the G function: rotations 32/24 for the first half, 16/63 for the second
    function automatic quad_t half_g(input quad_t q, input logic [63:0] x,
                                     input logic first);
        quad_t r;
        logic [63:0] t;
        r.a = q.a + q.b + x;
        t   = q.d ^ r.a;
        r.d = first ? {t[31:0], t[63:32]} : {t[15:0], t[63:16]};
        r.c = q.c + r.d;
        t   = q.b ^ r.c;
        r.b = first ? {t[23:0], t[63:24]} : {t[62:0], t[63]};
        return r;
    endfunction

endpackage

// ----- rtl/bhc_cell.sv -----
// One pipeline cell: four parallel half G steps of one BLAKE2b round
module bhc_cell import bhc_pkg::*; #(
    parameter int RND   = 0,
    parameter int PHASE = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  hash_words_t hash_words,
    input  stage_t      stage_i,
    output stage_t      stage_o
);

    stage_t stage_reg;
    stage_t stage_next;

    always_comb begin
        logic [15:0][63:0] msg;
        quad_t q;
        quad_t r;
        int ib;
        int ic;
        int id;
        msg = '0;
        msg[0] = stage_i.nonce;
        for (int k = 0; k < 4; k++) begin
            msg[k + 1] = hash_words[k];
        end
        stage_next = stage_i;
        for (int g = 0; g < 4; g++) begin
            ib = (PHASE >= 2) ? 4 + ((g + 1) % 4)  : 4 + g;
            ic = (PHASE >= 2) ? 8 + ((g + 2) % 4)  : 8 + g;
            id = (PHASE >= 2) ? 12 + ((g + 3) % 4) : 12 + g;
            q.a = stage_i.v[g];
            q.b = stage_i.v[ib];
            q.c = stage_i.v[ic];
            q.d = stage_i.v[id];
            r = half_g(q, msg[MSG_PERM[RND][2 * g + ((PHASE >= 2) ? 8 : 0) + (PHASE % 2)]],
                       (PHASE % 2) == 0);
            stage_next.v[g]  = r.a;
            stage_next.v[ib] = r.b;
            stage_next.v[ic] = r.c;
            stage_next.v[id] = r.d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg.valid <= stage_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg.nonce <= stage_next.nonce;
            stage_reg.v     <= stage_next.v;
        end
    end

    assign stage_o = stage_reg;

endmodule

// ----- rtl/pow_hash_threshold_check.sv -----
// Top level of the BLAKE2b proof-of-work nonce checker
//
// Input channel s_*: one 64-bit nonce per beat. Result channel m_*: one beat per
// nonce with the nonce, the 64-bit BLAKE2b digest and the threshold flag.
// The hash runs through a chain of 48 cells, each doing half of the G steps
// of one column or diagonal pass, so a new nonce enters every cycle unless the
// receiver stalls. Input beat to m_tvalid passes the 48 cells and the output
// register; throughput one beat per cycle while the receiver does not stall.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0..3 block
// hash words, 4 difficulty); other indexes are dropped. Write only while idle.
// Reset (synchronous, aresetn low) empties the chain and clears the config registers.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_tready drops; results keep their order and none is lost.
module pow_hash_threshold_check import bhc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,     // work_nonce[63:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,     // nonce_echo[63:0], digest_value[127:64],
                                      // meets_threshold[128], zero[135:129]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

`include "pow_hash_threshold_check_defines.svh"

    hash_words_t hash_reg;
    logic [63:0] difficulty_reg;
    stage_t      chain [CELL_COUNT + 1];
    logic        adv;

    logic        m_valid_reg;
    logic [63:0] nonce_reg;
    logic [63:0] digest_reg;
    logic        meets_reg;
    logic [63:0] digest_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg       <= '0;
            difficulty_reg <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_HASH_W0:    hash_reg[0]    <= cfg_wdata;
                REG_HASH_W1:    hash_reg[1]    <= cfg_wdata;
                REG_HASH_W2:    hash_reg[2]    <= cfg_wdata;
                REG_HASH_W3:    hash_reg[3]    <= cfg_wdata;
                REG_DIFFICULTY: difficulty_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    assign chain[0].valid = s_tvalid;
    assign chain[0].nonce = s_tdata;
    assign chain[0].v     = init_state();

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        bhc_cell #(
            .RND   (k / PHASES),
            .PHASE (k % PHASES)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .hash_words (hash_reg),
            .stage_i    (chain[k]),
            .stage_o    (chain[k + 1])
        );
    end

    assign digest_next = H0 ^ chain[CELL_COUNT].v[0] ^ chain[CELL_COUNT].v[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain[CELL_COUNT].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nonce_reg  <= chain[CELL_COUNT].nonce;
            digest_reg <= digest_next;
            meets_reg  <= (digest_next >= difficulty_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, meets_reg, digest_reg, nonce_reg};

    `BHC_ASSERT_NOW(a_no_accept_on_stall, m_tvalid && !m_tready, !s_tready,
        "input accepted while result stalled")
    `BHC_ASSERT_NEXT(a_last_cell_to_out, chain[CELL_COUNT].valid && adv, m_tvalid,
        "last cell beat did not reach output")
    `BHC_ASSERT_NOW(a_flag_matches, m_tvalid, meets_reg == (digest_reg >= difficulty_reg),
        "threshold flag inconsistent with digest")

endmodule

// ----- verif/tb_pow_hash_threshold_check.sv -----
// Testbench for the BLAKE2b proof-of-work nonce checker: random nonces, register sweeps, scoreboard
`timescale 1ns / 100ps

class pow_scoreboard;
    logic [63:0] hash_words [4];
    logic [63:0] difficulty;
    logic [135:0] pending_beats [$];
    int unsigned mismatches;

    function new();
        for (int i = 0; i < 4; i++) hash_words[i] = '0;
        difficulty = '0;
        mismatches = 0;
    endfunction

    function void set_reg(bhc_pkg::reg_index_t idx, logic [63:0] value);
        case (idx)
            bhc_pkg::REG_HASH_W0: hash_words[0] = value;
            bhc_pkg::REG_HASH_W1: hash_words[1] = value;
            bhc_pkg::REG_HASH_W2: hash_words[2] = value;
            bhc_pkg::REG_HASH_W3: hash_words[3] = value;
            bhc_pkg::REG_DIFFICULTY: difficulty = value;
            default: ;
        endcase
    endfunction

    static function logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function logic [63:0] blake_digest(logic [63:0] nonce);
        logic [63:0] m [16];
        logic [63:0] v [16];
        logic [63:0] iv [8];
        logic [63:0] h0;
        int sig [12][16];
        int ga [8], gb [8], gc [8], gd [8];
        sig = '{
            '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
            '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
            '{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
            '{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
            '{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
            '{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
            '{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
            '{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
            '{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
            '{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0},
            '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
            '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3}};
        ga = '{0, 1, 2, 3, 0, 1, 2, 3};
        gb = '{4, 5, 6, 7, 5, 6, 7, 4};
        gc = '{8, 9, 10, 11, 10, 11, 8, 9};
        gd = '{12, 13, 14, 15, 15, 12, 13, 14};
        iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
               64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
               64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        for (int i = 0; i < 16; i++) m[i] = '0;
        m[0] = nonce;
        for (int i = 0; i < 4; i++) m[1 + i] = hash_words[i];
        h0 = iv[0] ^ 64'h0101_0008;
        for (int i = 0; i < 8; i++) begin
            v[i] = iv[i];
            v[8 + i] = iv[i];
        end
        v[0] = h0;
        v[12] = v[12] ^ 64'd40;
        v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
                v[ga[g]] = v[ga[g]] + v[gb[g]] + m[sig[r][2 * g]];
                v[gd[g]] = rotr(v[gd[g]] ^ v[ga[g]], 32);
                v[gc[g]] = v[gc[g]] + v[gd[g]];
                v[gb[g]] = rotr(v[gb[g]] ^ v[gc[g]], 24);
                v[ga[g]] = v[ga[g]] + v[gb[g]] + m[sig[r][2 * g + 1]];
                v[gd[g]] = rotr(v[gd[g]] ^ v[ga[g]], 16);
                v[gc[g]] = v[gc[g]] + v[gd[g]];
                v[gb[g]] = rotr(v[gb[g]] ^ v[gc[g]], 63);
            end
        end
        return h0 ^ v[0] ^ v[8];
    endfunction

    function void note_nonce(logic [63:0] nonce);
        logic [63:0] dig;
        dig = blake_digest(nonce);
        pending_beats.push_back({7'd0, (dig >= difficulty), dig, nonce});
    endfunction

    function void check_beat(logic [135:0] got);
        logic [135:0] want;
        if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        want = pending_beats.pop_front();
        if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]
                || got[128] !== want[128]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: nonce %h/%h digest %h/%h flag %b/%b (exp/act)",
                         want[63:0], got[63:0], want[127:64], got[127:64],
                         want[128], got[128]);
        end
    endfunction
endclass

module tb_pow_hash_threshold_check;
    import bhc_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;

    pow_scoreboard sb;
    bit long_stall;

    pow_hash_threshold_check dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // hold the write enable; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx <= REG_DIFFICULTY) sb.set_reg(reg_index_t'(idx), value);
    endtask

    task automatic send_nonce(logic [63:0] nonce, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= nonce;
        do @(posedge aclk); while (!s_tready);
        sb.note_nonce(nonce);
    endtask

    task automatic drain();
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic run_phase(int count, bit burst);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: send_nonce(64'd0, burst);
                1: send_nonce('1, burst);
                default: send_nonce(rand64(), burst || ($urandom_range(0, 3) == 0));
            endcase
        end
        s_tvalid <= 1'b0;
    endtask

    // receiver: random stalls per beat, one long hold-off on request
    initial begin
        int wait_cycles;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_stall) begin
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
                long_stall = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    initial begin
        logic [63:0] directed [8];
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers, then extremes of the nonce
        directed = '{64'd0, '1, 64'd1, 64'h8000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                     64'h0123_4567_89ab_cdef, 64'h7fff_ffff_ffff_ffff};
        foreach (directed[i]) send_nonce(directed[i], i < 4);
        s_tvalid <= 1'b0;
        drain();

        // all-ones hash words and threshold, plus an out-of-range index
        for (int i = 0; i < 5; i++) write_reg(i[2:0], '1);
        write_reg(3'd7, 64'h1234);
        cfg_wr_en <= 1'b0;
        foreach (directed[i]) send_nonce(directed[i], 1'b1);
        s_tvalid <= 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 4; i++) write_reg(i[2:0], rand64());
            case (ph % 3)
                0: write_reg(REG_DIFFICULTY, 64'd0);
                1: write_reg(REG_DIFFICULTY, 64'h8000_0000_0000_0000);
                default: write_reg(REG_DIFFICULTY, rand64());
            endcase
            cfg_wr_en <= 1'b0;
            if (ph == 2) begin
                long_stall = 1'b1;
                run_phase(120, 1'b1);
            end else begin
                run_phase(160, 1'b0);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
